@@ rtl/bcpe_pkg.sv @@
`default_nettype none

package bcpe_pkg;

    localparam logic DEGREE_QUADRATIC = 1'b0;
    localparam logic DEGREE_CUBIC     = 1'b1;

    localparam int STEPS_PER_CELL = 3;
    localparam int CURVE_LEVELS   = 3;
    localparam int PIPE_DEPTH     = STEPS_PER_CELL * CURVE_LEVELS;

    typedef struct packed {
        logic diff;
        logic mult;
        logic sum;
    } bcpe_step_en_t;

endpackage

`default_nettype wire

@@ rtl/bcpe_lerp_cell.sv @@
`default_nettype none

module bcpe_lerp_cell #(
    parameter int COORD_WIDTH         = 32,
    parameter int PARAM_FRACTION_BITS = 16
) (
    input  wire                          aclk,
    input  bcpe_pkg::bcpe_step_en_t      step_en,
    input  wire  [COORD_WIDTH-1:0]       near_in,
    input  wire  [COORD_WIDTH-1:0]       far_in,
    input  wire  [PARAM_FRACTION_BITS:0] param_in,
    input  wire                          mode_in,
    output logic [COORD_WIDTH-1:0]       point_out,
    output logic [PARAM_FRACTION_BITS:0] param_out,
    output logic                         mode_out
);
    import bcpe_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int F      = PARAM_FRACTION_BITS;
    localparam int DIFF_W = W + 1;
    localparam int PROD_W = W + F + 3;

    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic        [W-1:0]      near_d_reg;
    logic        [F:0]        param_d_reg;
    logic                     mode_d_reg;

    logic signed [F+1:0]      param_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [W-1:0]      near_p_reg;
    logic        [F:0]        param_p_reg;
    logic                     mode_p_reg;

    logic        [W-1:0]      shift_val;
    logic        [W-1:0]      point_next;
    logic        [W-1:0]      point_reg;
    logic        [F:0]        param_o_reg;
    logic                     mode_o_reg;

    assign diff_next  = $signed({far_in[W-1], far_in}) - $signed({near_in[W-1], near_in});
    assign param_s    = $signed({1'b0, param_d_reg});
    assign prod_next  = PROD_W'(diff_reg) * PROD_W'(param_s);
    assign shift_val  = W'(prod_reg >>> F);
    assign point_next = near_p_reg + shift_val;

    always_ff @(posedge aclk) begin
        if (step_en.diff) begin
            diff_reg    <= diff_next;
            near_d_reg  <= near_in;
            param_d_reg <= param_in;
            mode_d_reg  <= mode_in;
        end
        if (step_en.mult) begin
            prod_reg    <= prod_next;
            near_p_reg  <= near_d_reg;
            param_p_reg <= param_d_reg;
            mode_p_reg  <= mode_d_reg;
        end
        if (step_en.sum) begin
            point_reg   <= point_next;
            param_o_reg <= param_p_reg;
            mode_o_reg  <= mode_p_reg;
        end
    end

    assign point_out = point_reg;
    assign param_out = param_o_reg;
    assign mode_out  = mode_o_reg;

endmodule

`default_nettype wire

@@ rtl/bezier_curve_point_evaluator.sv @@
`default_nettype none

// Evaluates one axis of a quadratic or cubic Bezier curve at parameter t by
// de Casteljau: three levels of interpolation cells (three, two and one cell),
// each cell a three-step pipeline (difference, multiply, shift and add); a new item
// is taken every cycle until a stalled result backs up to the input. A stalled
// result holds the pipeline stage by stage; empty stages still fill, so input is
// accepted until every stage holds an item. s_tuser carries degree_mode (1 cubic,
// 0 quadratic); t above one is clamped to one, and each interpolation is floored.
module bezier_curve_point_evaluator #(
    parameter int COORD_WIDTH         = 32,
    parameter int PARAM_FRACTION_BITS = 16,
    localparam int S_DATA_W = ((4 * COORD_WIDTH + PARAM_FRACTION_BITS + 1 + 7) / 8) * 8,
    localparam int M_DATA_W = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    // start_point, first_control, second_control, end_point, curve_param
    input  wire  [S_DATA_W-1:0] s_tdata,
    // degree_mode
    input  wire                 s_tuser,
    output logic                m_tvalid,
    input  wire                 m_tready,
    // curve_value
    output logic [M_DATA_W-1:0] m_tdata
);
    import bcpe_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int F = PARAM_FRACTION_BITS;
    localparam logic [F:0] FRAC_ONE = (F + 1)'(1) << F;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [PIPE_DEPTH-1:0] rdy;
    bcpe_step_en_t         level_en [CURVE_LEVELS];

    logic [W-1:0] p0, p1, p2, p3;
    logic [F:0]   param_in, param_sat;
    logic         cubic_in;

    logic [W-1:0] q0, q1, q2, s0, s1, r0;
    logic [F:0]   param_l1, param_l2;
    logic         mode_l1, mode_l2;

    assign p0        = s_tdata[W-1:0];
    assign p1        = s_tdata[2*W-1:W];
    assign p2        = s_tdata[3*W-1:2*W];
    assign p3        = s_tdata[4*W-1:3*W];
    assign param_in  = s_tdata[4*W+F:4*W];
    assign param_sat = param_in[F] ? FRAC_ONE : param_in;
    assign cubic_in  = (s_tuser == DEGREE_CUBIC);

    always_comb begin
        rdy[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || m_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
        for (int l = 0; l < CURVE_LEVELS; l++) begin
            level_en[l].diff = rdy[STEPS_PER_CELL*l];
            level_en[l].mult = rdy[STEPS_PER_CELL*l+1];
            level_en[l].sum  = rdy[STEPS_PER_CELL*l+2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    bcpe_lerp_cell #(.COORD_WIDTH(W), .PARAM_FRACTION_BITS(F)) u_cell_q0 (
        .aclk(aclk), .step_en(level_en[0]),
        .near_in(p0), .far_in(p1), .param_in(param_sat), .mode_in(cubic_in),
        .point_out(q0), .param_out(param_l1), .mode_out(mode_l1)
    );

    bcpe_lerp_cell #(.COORD_WIDTH(W), .PARAM_FRACTION_BITS(F)) u_cell_q1 (
        .aclk(aclk), .step_en(level_en[0]),
        .near_in(p1), .far_in(cubic_in ? p2 : p3), .param_in(param_sat), .mode_in(cubic_in),
        .point_out(q1), .param_out(), .mode_out()
    );

    bcpe_lerp_cell #(.COORD_WIDTH(W), .PARAM_FRACTION_BITS(F)) u_cell_q2 (
        .aclk(aclk), .step_en(level_en[0]),
        .near_in(p2), .far_in(p3), .param_in(param_sat), .mode_in(cubic_in),
        .point_out(q2), .param_out(), .mode_out()
    );

    bcpe_lerp_cell #(.COORD_WIDTH(W), .PARAM_FRACTION_BITS(F)) u_cell_s0 (
        .aclk(aclk), .step_en(level_en[1]),
        .near_in(q0), .far_in(q1), .param_in(param_l1), .mode_in(mode_l1),
        .point_out(s0), .param_out(param_l2), .mode_out(mode_l2)
    );

    bcpe_lerp_cell #(.COORD_WIDTH(W), .PARAM_FRACTION_BITS(F)) u_cell_s1 (
        .aclk(aclk), .step_en(level_en[1]),
        .near_in(q1), .far_in(q2), .param_in(param_l1), .mode_in(mode_l1),
        .point_out(s1), .param_out(), .mode_out()
    );

    // quadratic: interpolate s0 with itself to pass it through unchanged
    bcpe_lerp_cell #(.COORD_WIDTH(W), .PARAM_FRACTION_BITS(F)) u_cell_r0 (
        .aclk(aclk), .step_en(level_en[2]),
        .near_in(s0), .far_in(mode_l2 ? s1 : s0), .param_in(param_l2), .mode_in(mode_l2),
        .point_out(r0), .param_out(), .mode_out()
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = M_DATA_W'(r0);

endmodule

`default_nettype wire

@@ rtl/bcpe_port_check.sv @@
`default_nettype none

module bcpe_port_check #(
    parameter int COORD_WIDTH         = 32,
    parameter int PARAM_FRACTION_BITS = 16,
    localparam int S_DATA_W = ((4 * COORD_WIDTH + PARAM_FRACTION_BITS + 1 + 7) / 8) * 8,
    localparam int M_DATA_W = ((COORD_WIDTH + 7) / 8) * 8
) (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tvalid,
    input wire                s_tready,
    input wire [S_DATA_W-1:0] s_tdata,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata
);
    import bcpe_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int F = PARAM_FRACTION_BITS;

    logic         s_acc;
    logic [F:0]   s_param;
    logic [W-1:0] s_start;
    logic [W-1:0] s_end;

    assign s_acc   = s_tvalid && s_tready;
    assign s_param = s_tdata[4*W+F:4*W];
    assign s_start = s_tdata[W-1:0];
    assign s_end   = s_tdata[4*W-1:3*W];

    sequence drain_open;
        m_tready ##1 m_tready ##1 m_tready ##1 m_tready
            ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready;
    endsequence

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_param == '0) ##1 drain_open
        |=> m_tvalid && (m_tdata[W-1:0] == $past(s_start, PIPE_DEPTH)))
        else $error("t of zero did not give the start point");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_param[F] ##1 drain_open
        |=> m_tvalid && (m_tdata[W-1:0] == $past(s_end, PIPE_DEPTH)))
        else $error("t of one did not give the end point");

endmodule

bind bezier_curve_point_evaluator bcpe_port_check #(
    .COORD_WIDTH(COORD_WIDTH),
    .PARAM_FRACTION_BITS(PARAM_FRACTION_BITS)
) u_port_check (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bcpe_pkg::*;

    localparam int COORD_W      = 32;
    localparam int FRAC_BITS    = 16;
    localparam int S_DATA_W     = ((4 * COORD_W + FRAC_BITS + 1 + 7) / 8) * 8;
    localparam int M_DATA_W     = ((COORD_W + 7) / 8) * 8;
    localparam int T_ONE        = 1 << FRAC_BITS;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_ITEMS  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * PIPE_DEPTH;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [FRAC_BITS:0]        param_t;

    typedef struct packed {
        logic   mode;
        coord_t p0;
        coord_t p1;
        coord_t p2;
        coord_t p3;
        param_t t;
        logic   known;
        coord_t value;
    } curve_row_t;

    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam coord_t C_MAX = 32'sh7FFF_FFFF;

    localparam int NUM_ROWS = 18;
    localparam curve_row_t CURVE_ROWS [0:NUM_ROWS-1] = '{
        '{DEGREE_QUADRATIC, 32'sh0001_0000, 32'sh0005_0000, 32'sh1234_5678, 32'sh0003_0000,
          17'd0, 1'b1, 32'sh0001_0000},
        '{DEGREE_CUBIC, C_MIN, C_MAX, C_MIN, C_MAX, 17'd0, 1'b1, C_MIN},
        '{DEGREE_CUBIC, C_MIN, C_MAX, C_MIN, C_MAX, 17'd65536, 1'b1, C_MAX},
        '{DEGREE_QUADRATIC, C_MAX, C_MIN, 32'sh0, C_MIN, 17'd65536, 1'b1, C_MIN},
        '{DEGREE_CUBIC, 32'sh0002_0000, 32'shFFF0_0000, 32'sh0777_0000, 32'sh1111_0000,
          17'd65537, 1'b1, 32'sh1111_0000},
        '{DEGREE_QUADRATIC, 32'shDEAD_BEEF, 32'sh0BAD_F00D, 32'shFFFF_FFFF, 32'shCAFE_0001,
          17'd131071, 1'b1, 32'shCAFE_0001},
        '{DEGREE_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX, 17'd32768, 1'b1, C_MAX},
        '{DEGREE_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, 17'd12345, 1'b1, C_MIN},
        '{DEGREE_CUBIC, C_MAX, C_MIN, C_MAX, C_MIN, 17'd131071, 1'b1, C_MIN},
        '{DEGREE_QUADRATIC, 32'sh0, 32'sh0064_0000, 32'sh5555_5555, 32'sh00C8_0000,
          17'd32768, 1'b0, 32'sh0},
        '{DEGREE_CUBIC, C_MIN, C_MAX, C_MIN, C_MAX, 17'd32768, 1'b0, 32'sh0},
        '{DEGREE_QUADRATIC, C_MIN, C_MAX, C_MAX, C_MIN, 17'd32768, 1'b0, 32'sh0},
        '{DEGREE_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, 17'd1, 1'b0, 32'sh0},
        '{DEGREE_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, 17'd65535, 1'b0, 32'sh0},
        '{DEGREE_QUADRATIC, C_MAX, C_MIN, C_MIN, C_MAX, 17'd1, 1'b0, 32'sh0},
        '{DEGREE_QUADRATIC, 32'shFFFE_0000, 32'shFFF0_8000, 32'sh0, 32'shFFFF_FFFF,
          17'h0AAAA, 1'b0, 32'sh0},
        '{DEGREE_CUBIC, 32'sh0, 32'shFFFF_FFFF, 32'sh0, 32'shFFFF_FFFF, 17'h15555 & 17'hFFFF,
          1'b0, 32'sh0},
        '{DEGREE_QUADRATIC, 32'sh0, 32'shFFFF_FFFF, 32'sh7FFF_0000, 32'sh1, 17'd3,
          1'b0, 32'sh0}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    coord_t expected_points[$];
    int     mismatches = 0;
    int     stall_cycles = 0;
    int     send_idle_pct;
    int     recv_idle_pct;

    bezier_curve_point_evaluator #(
        .COORD_WIDTH         (COORD_W),
        .PARAM_FRACTION_BITS (FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic coord_t lerp_floor(input coord_t a, input coord_t b, input param_t t);
        longint diff;
        longint scaled;
        diff   = longint'(b) - longint'(a);
        scaled = (diff * longint'({1'b0, t})) >>> FRAC_BITS;
        return coord_t'(longint'(a) + scaled);
    endfunction

    function automatic coord_t bezier_point(input logic mode, input coord_t p0,
                                            input coord_t p1, input coord_t p2,
                                            input coord_t p3, input param_t t_in);
        param_t t;
        coord_t q0;
        coord_t q1;
        coord_t q2;
        t = (t_in > param_t'(T_ONE)) ? param_t'(T_ONE) : t_in;
        if (mode == DEGREE_CUBIC) begin
            q0 = lerp_floor(p0, p1, t);
            q1 = lerp_floor(p1, p2, t);
            q2 = lerp_floor(p2, p3, t);
            return lerp_floor(lerp_floor(q0, q1, t), lerp_floor(q1, q2, t), t);
        end
        q0 = lerp_floor(p0, p1, t);
        q1 = lerp_floor(p1, p3, t);
        return lerp_floor(q0, q1, t);
    endfunction

    function automatic coord_t random_coord();
        case ($urandom_range(0, 9))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return coord_t'($urandom_range(0, 400)) - 200;
            3:       return coord_t'($urandom_range(0, 255)) <<< FRAC_BITS;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic param_t random_param();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return param_t'(T_ONE);
            2:       return param_t'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
            3:       return param_t'($urandom_range(0, 15));
            4:       return param_t'($urandom_range(T_ONE - 16, T_ONE));
            default: return param_t'($urandom_range(0, T_ONE));
        endcase
    endfunction

    task automatic send_curve(input logic mode, input coord_t p0, input coord_t p1,
                              input coord_t p2, input coord_t p3, input param_t t,
                              input coord_t point);
        logic [S_DATA_W-1:0] data;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        data = '0;
        data[4*COORD_W +: FRAC_BITS+1] = t;
        data[0 +: 4*COORD_W]           = {p3, p2, p1, p0};
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        expected_points.push_back(point);
    endtask

    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 99) < recv_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected curve_value %h", m_tdata);
            end else begin
                coord_t want;
                want = expected_points.pop_front();
                if (m_tdata[COORD_W-1:0] !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("curve_value mismatch: expected %h actual %h", want,
                                 m_tdata[COORD_W-1:0]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        curve_row_t row;
        logic       mode;
        coord_t     p0;
        coord_t     p1;
        coord_t     p2;
        coord_t     p3;
        param_t     t;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= DEGREE_QUADRATIC;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = CURVE_ROWS[i];
            send_idle_pct = (i % 3 == 0) ? 40 : 0;
            recv_idle_pct = (i % 4 == 1) ? 40 : 0;
            send_curve(row.mode, row.p0, row.p1, row.p2, row.p3, row.t,
                       row.known ? row.value
                                 : bezier_point(row.mode, row.p0, row.p1, row.p2,
                                                row.p3, row.t));
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (i % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 5;
                    default: send_idle_pct = 25;
                endcase
                case ($urandom_range(0, 3))
                    0:       recv_idle_pct = 0;
                    1:       recv_idle_pct = 5;
                    default: recv_idle_pct = 25;
                endcase
            end
            mode = 1'($urandom_range(0, 1));
            p0   = random_coord();
            p1   = random_coord();
            p2   = random_coord();
            p3   = random_coord();
            t    = random_param();
            send_curve(mode, p0, p1, p2, p3, t, bezier_point(mode, p0, p1, p2, p3, t));
        end
        s_tvalid <= 1'b0;

        while (expected_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
